// ===== src/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared constants, types and per-byte frame functions of the receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  // Line codes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Check polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Frame byte counter limits
  localparam int unsigned IDX_W      = 17;
  localparam logic [IDX_W-1:0] IDX_MAX   = 17'h1FFFF;
  localparam logic [IDX_W-1:0] HDR_BYTES = 17'd4;
  localparam logic [IDX_W-1:0] MIN_BYTES = 17'd6;

  // Result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned TDATA_W    = 48;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_LEN_ERR   = 2'd2,
    ST_CHECK_ERR = 2'd3
  } status_t;

  // Per-frame working state
  typedef struct packed {
    logic             esc;
    logic [IDX_W-1:0] idx;
    logic [15:0]      typ;
    logic [15:0]      len;
    logic [15:0]      crc;
    logic [31:0]      sum;
    logic [15:0]      stored;
    logic [7:0]       hold;
  } frame_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] msg_type;
    logic [15:0] frame_len;
    status_t     status;
  } result_t;

  // Push requests from the decoder to the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  typedef struct packed {
    frame_t f;
    logic   emit;
  } take_t;

  // CRC-16 update over one byte, MSB first; data bits enter at the bottom.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    logic        carry;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      carry = c[15];
      c = {c[14:0], 1'b0};
      if (carry) c = c ^ CRC_POLY;
      if (b[i]) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Handle one decoded frame byte: header capture, payload, stored check.
  function automatic take_t take_byte(input frame_t f_in, input logic [7:0] b);
    take_t            t;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] len_end;
    logic             acc;
    t.f     = f_in;
    t.emit  = 1'b0;
    acc     = 1'b0;
    pos     = f_in.idx;
    len_end = HDR_BYTES + {1'b0, f_in.len};
    if (pos < HDR_BYTES) begin
      case (pos[1:0])
        2'd0:    t.f.typ[15:8] = b;
        2'd1:    t.f.typ[7:0]  = b;
        2'd2:    t.f.len[15:8] = b;
        default: t.f.len[7:0]  = b;
      endcase
      acc = 1'b1;
    end else if (pos < len_end) begin
      t.emit = 1'b1;
      acc    = 1'b1;
    end else if (pos == len_end) begin
      t.f.hold = b;
    end else if (pos == len_end + 17'd1) begin
      t.f.stored = {f_in.hold, b};
    end
    // Running checks over header and payload; even positions are high halves.
    if (acc) begin
      t.f.crc = crc_byte(f_in.crc, b);
      t.f.sum = f_in.sum + (pos[0] ? {24'd0, b} : {16'd0, b, 8'd0});
    end
    if (f_in.idx != IDX_MAX) t.f.idx = f_in.idx + 17'd1;
    return t;
  endfunction

  // Verdict for a closed frame.
  function automatic status_t verdict_status(input frame_t f, input logic counting);
    logic [IDX_W-1:0] need;
    logic [16:0]      s1;
    logic [16:0]      s2;
    logic [15:0]      chk;
    status_t          st;
    need = MIN_BYTES + {1'b0, f.len};
    s1   = {1'b0, f.sum[31:16]} + {1'b0, f.sum[15:0]};
    s2   = s1 + {16'd0, s1[16]};
    chk  = ~s2[15:0];
    if (f.idx < MIN_BYTES) begin
      st = ST_SHORT;
    end else if (counting ? (f.idx != need) : (f.idx < need)) begin
      st = ST_LEN_ERR;
    end else if (f.stored == f.crc || f.stored == chk) begin
      st = ST_OK;
    end else begin
      st = ST_CHECK_ERR;
    end
    return st;
  endfunction

endpackage

// ===== src/escaped_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver with CRC-16
// Recovers flag-delimited frames from a received byte stream and reports
// payload bytes and a verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
// Line bytes enter on the s_ channel, one per request, in s_tdata[7:0].
// Results leave on the m_ channel: m_tuser[0] is 0 for a payload byte and
// 1 for a frame verdict; m_tdata carries the byte, the type, the length
// and the status. A verdict is always the last request a byte causes.
// cfg_wr_en/cfg_wr_data write the transcode-off mode bit; write it only
// while the block is idle.
// Throughput is one byte per cycle while the result queue has room. A byte
// is held in an input register until the queue has room, decoded there in
// a single pass, and its results are written to a four-entry result queue
// that offers them on m_ in order. A byte that gives two results offers
// them on m_ one after the other.
// When the receiver stalls, the queue fills and then s_tready drops; no
// request is lost. Reset clears the mode, the frame state and the queue;
// the block then hunts for an opening flag.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc16 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [efr_pkg::TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [23:8] msg_type,
                                                 // [39:24] frame_len, [41:40] status
  output logic [0:0]                  m_tuser    // [0] kind
);

  logic                      in_valid;
  logic [7:0]                in_byte;
  logic                      go;
  logic                      room;
  logic [efr_pkg::FIFO_AW:0] level;
  efr_pkg::push_t            push;
  efr_pkg::result_t          res0;
  efr_pkg::result_t          res1;
  efr_pkg::result_t          head;

  assign go       = in_valid && room;
  assign s_tready = !in_valid || go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  efr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .in_byte     (in_byte),
    .push        (push),
    .res0        (res0),
    .res1        (res1)
  );

  efr_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .head      (head),
    .room      (room),
    .level     (level)
  );

  // Output packing
  assign m_tuser = head.kind;
  assign m_tdata = {6'd0, head.status, head.frame_len, head.msg_type, head.data_byte};

  // Checks
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  assert property (@(posedge clk) disable iff (rst)
    level <= (efr_pkg::FIFO_AW + 1)'(efr_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst) push.push1 |-> push.push0)
    else $error("second result without a first");

  assert property (@(posedge clk) disable iff (rst)
    (push.push0 || push.push1) |-> go)
    else $error("result request without a decoded byte");

endmodule

// ===== src/efr_core.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver decoder
// Flag hunting, escape decoding, header capture, checks and verdicts for one
// registered byte per cycle while go is high; gives up to two result requests per byte.
// ----------------------------------------------------------------------------
module efr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             go,
  input  logic [7:0]       in_byte,
  output efr_pkg::push_t   push,
  output efr_pkg::result_t res0,
  output efr_pkg::result_t res1
);

  logic            transcode_off;
  logic            framing;
  logic            framing_next;
  efr_pkg::frame_t frame;
  efr_pkg::frame_t frame_next;

  // Mode register and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      transcode_off <= 1'b0;
      framing       <= 1'b0;
      frame         <= '0;
    end else begin
      if (cfg_wr_en) transcode_off <= cfg_wr_data;
      if (go) begin
        framing <= framing_next;
        frame   <= frame_next;
      end
    end
  end

  // Decode of the current byte
  always_comb begin
    efr_pkg::frame_t  fe;
    efr_pkg::take_t   tk_flag;
    efr_pkg::take_t   tk_data;
    efr_pkg::result_t pay;
    efr_pkg::result_t ver;
    logic [7:0]       data_in;
    logic             is_flag;

    is_flag = (in_byte == efr_pkg::FLAG_BYTE);
    fe      = frame;
    fe.esc  = 1'b0;
    data_in = (frame.esc && !transcode_off) ? (in_byte ^ efr_pkg::ESC_XOR) : in_byte;
    tk_flag = efr_pkg::take_byte(fe, efr_pkg::ESC_BYTE);
    tk_data = efr_pkg::take_byte(fe, data_in);

    pay           = '0;
    pay.kind      = efr_pkg::KIND_PAYLOAD;
    ver           = '0;
    ver.kind      = efr_pkg::KIND_VERDICT;

    framing_next  = framing;
    frame_next    = frame;
    push          = '0;
    res0          = '0;
    res1          = '0;

    if (!framing) begin
      // Hunting for an opening flag
      if (is_flag) begin
        framing_next = 1'b1;
        frame_next   = '0;
      end
    end else if (transcode_off) begin
      // Length counting mode
      frame_next = fe;
      if (!is_flag) begin
        frame_next  = tk_data.f;
        pay.data_byte = data_in;
        push.push0  = tk_data.emit;
        res0        = pay;
      end else if (frame.idx != '0) begin
        if (frame.idx >= efr_pkg::MIN_BYTES + {1'b0, frame.len}) begin
          ver.msg_type  = frame.typ;
          ver.frame_len = frame.len;
          ver.status    = efr_pkg::verdict_status(fe, 1'b1);
          push.push0    = 1'b1;
          res0          = ver;
          framing_next  = 1'b0;
        end
        frame_next = '0;
      end
    end else if (is_flag) begin
      // Closing flag in escape mode, with a possible trailing escape byte
      if (frame.idx != '0 || frame.esc) begin
        if (frame.esc) begin
          ver.msg_type  = tk_flag.f.typ;
          ver.frame_len = tk_flag.f.len;
          ver.status    = efr_pkg::verdict_status(tk_flag.f, 1'b0);
        end else begin
          ver.msg_type  = frame.typ;
          ver.frame_len = frame.len;
          ver.status    = efr_pkg::verdict_status(fe, 1'b0);
        end
        pay.data_byte = efr_pkg::ESC_BYTE;
        if (frame.esc && tk_flag.emit) begin
          push.push0 = 1'b1;
          push.push1 = 1'b1;
          res0       = pay;
          res1       = ver;
        end else begin
          push.push0 = 1'b1;
          res0       = ver;
        end
        framing_next = 1'b0;
        frame_next   = '0;
      end
    end else if (!frame.esc && in_byte == efr_pkg::ESC_BYTE) begin
      // Escape marker
      frame_next.esc = 1'b1;
    end else begin
      // Plain or unescaped data byte
      frame_next    = tk_data.f;
      pay.data_byte = data_in;
      push.push0    = tk_data.emit;
      res0          = pay;
    end

    // Requests go out only for a byte that is taken in this cycle.
    if (!go) push = '0;
  end

endmodule

// ===== src/efr_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver result queue
// Small register queue that takes up to two result requests per cycle and
// presents one per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module efr_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  efr_pkg::push_t             push,
  input  efr_pkg::result_t           res0,
  input  efr_pkg::result_t           res1,
  input  logic                       pop_ready,
  output logic                       out_valid,
  output efr_pkg::result_t           head,
  output logic                       room,
  output logic [efr_pkg::FIFO_AW:0]  level
);

  efr_pkg::result_t              mem [efr_pkg::FIFO_DEPTH];
  logic [efr_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [efr_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [efr_pkg::FIFO_AW:0]     count;
  logic [efr_pkg::FIFO_AW:0]     count_next;
  logic                          pop;
  logic [efr_pkg::FIFO_AW-1:0]   wr_ptr1;

  assign out_valid = (count != '0);
  assign pop       = out_valid && pop_ready;
  assign head      = mem[rd_ptr];
  assign level     = count;
  assign wr_ptr1   = wr_ptr + 1'b1;

  // Room for two requests, whatever is taken this cycle
  assign room = (count <= (efr_pkg::FIFO_AW + 1)'(efr_pkg::FIFO_DEPTH - 2));

  assign count_next = count + {{efr_pkg::FIFO_AW{1'b0}}, push.push0}
                    + {{efr_pkg::FIFO_AW{1'b0}}, push.push1}
                    - {{efr_pkg::FIFO_AW{1'b0}}, pop};

  // Storage
  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_ptr] <= res0;
    if (push.push1) mem[wr_ptr1] <= res1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {{(efr_pkg::FIFO_AW-1){1'b0}}, push.push0}
                       + {{(efr_pkg::FIFO_AW-1){1'b0}}, push.push1};
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

endmodule

// ===== test/efr_checker.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver checker
// Watches the line-byte, result and mode-write ports of the receiver. It
// keeps its own model of the deframer and a queue of predicted results. Each
// result taken from the output channel is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module efr_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [efr_pkg::TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [23:8] msg_type,
                                                 // [39:24] frame_len, [41:40] status
  input  logic [0:0]                  m_tuser,   // [0] kind
  output int                          fail_count,
  output int                          pending_count
);

  // Model state of the deframer.
  logic        counting_mode;
  logic        frame_open;
  logic        esc_armed;
  logic [16:0] frame_count;
  logic [15:0] hdr_type;
  logic [15:0] hdr_len;
  logic [15:0] crc_run;
  logic [31:0] sum_run;
  logic [15:0] stored_chk;
  logic [7:0]  chk_hi;

  efr_pkg::result_t due_results[$];
  int               mismatches;

  // Start a fresh frame image; the open/hunting bit is kept.
  task automatic clear_frame_state;
    esc_armed   = 1'b0;
    frame_count = '0;
    hdr_type    = '0;
    hdr_len     = '0;
    crc_run     = '0;
    sum_run     = '0;
    stored_chk  = '0;
    chk_hi      = '0;
  endtask

  // One byte of the CRC-16: a bit that leaves the top and the data bit
  // entering at the bottom each fold the polynomial in, so they cancel.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      r = {r[14:0], 1'b0} ^ ((r[15] ^ b[k]) ? efr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // Status of a frame closed by a flag.
  function automatic efr_pkg::status_t close_status(input logic counting);
    logic [16:0] need;
    logic [16:0] folded;
    logic [15:0] word_chk;
    need     = 17'd6 + {1'b0, hdr_len};
    folded   = {1'b0, sum_run[31:16]} + {1'b0, sum_run[15:0]};
    folded   = folded + {16'd0, folded[16]};
    word_chk = ~folded[15:0];
    if (frame_count < 17'd6) return efr_pkg::ST_SHORT;
    if (counting ? (frame_count != need) : (frame_count < need)) return efr_pkg::ST_LEN_ERR;
    if (stored_chk == crc_run || stored_chk == word_chk) return efr_pkg::ST_OK;
    return efr_pkg::ST_CHECK_ERR;
  endfunction

  // One decoded frame byte: header, payload, or stored check.
  task automatic absorb_byte(input logic [7:0] b);
    logic [16:0]      pos;
    logic [16:0]      body_end;
    logic             summed;
    efr_pkg::result_t r;
    pos      = frame_count;
    body_end = 17'd4 + {1'b0, hdr_len};
    summed   = 1'b0;
    if (pos < 17'd4) begin
      case (pos[1:0])
        2'd0:    hdr_type[15:8] = b;
        2'd1:    hdr_type[7:0]  = b;
        2'd2:    hdr_len[15:8]  = b;
        default: hdr_len[7:0]   = b;
      endcase
      summed = 1'b1;
    end else if (pos < body_end) begin
      r           = '0;
      r.kind      = efr_pkg::KIND_PAYLOAD;
      r.data_byte = b;
      r.status    = efr_pkg::ST_OK;
      due_results.insert(due_results.size(), r);
      summed = 1'b1;
    end else if (pos == body_end) begin
      chk_hi = b;
    end else if (pos == body_end + 17'd1) begin
      stored_chk = {chk_hi, b};
    end
    if (summed) begin
      crc_run = crc_step(crc_run, b);
      sum_run = sum_run + (pos[0] ? {24'd0, b} : {16'd0, b, 8'd0});
    end
    if (frame_count != efr_pkg::IDX_MAX) frame_count = frame_count + 17'd1;
  endtask

  // Queue the verdict and go back to hunting.
  task automatic emit_verdict(input logic counting);
    efr_pkg::result_t r;
    r           = '0;
    r.kind      = efr_pkg::KIND_VERDICT;
    r.msg_type  = hdr_type;
    r.frame_len = hdr_len;
    r.status    = close_status(counting);
    due_results.insert(due_results.size(), r);
    frame_open = 1'b0;
    clear_frame_state();
  endtask

  // Predict what one accepted line byte causes.
  task automatic decode_line_byte(input logic [7:0] b);
    if (!frame_open) begin
      if (b == efr_pkg::FLAG_BYTE) begin
        frame_open = 1'b1;
        clear_frame_state();
      end
    end else if (counting_mode) begin
      // Length counting: no escapes, a flag only closes a complete frame.
      esc_armed = 1'b0;
      if (b != efr_pkg::FLAG_BYTE) begin
        absorb_byte(b);
      end else if (frame_count != '0) begin
        if (frame_count >= 17'd6 + {1'b0, hdr_len}) emit_verdict(1'b1);
        else clear_frame_state();
      end
    end else if (b == efr_pkg::FLAG_BYTE) begin
      // An escape right before the flag stands for itself.
      if (frame_count != '0 || esc_armed) begin
        if (esc_armed) begin
          esc_armed = 1'b0;
          absorb_byte(efr_pkg::ESC_BYTE);
        end
        emit_verdict(1'b0);
      end
    end else if (esc_armed) begin
      esc_armed = 1'b0;
      absorb_byte(b ^ efr_pkg::ESC_XOR);
    end else if (b == efr_pkg::ESC_BYTE) begin
      esc_armed = 1'b1;
    end else begin
      absorb_byte(b);
    end
  endtask

  // Sample all channels at the clock edge and compare results in order.
  always @(posedge clk) begin : watch
    efr_pkg::result_t want;
    if (rst) begin
      counting_mode = 1'b0;
      frame_open    = 1'b0;
      clear_frame_state();
      due_results.delete();
      mismatches = 0;
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_wr_en) counting_mode = cfg_wr_data;
      if (s_tvalid && s_tready) decode_line_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: kind %0d tdata %h", m_tuser[0], m_tdata);
          end
        end else begin
          want = due_results.pop_front();
          if (want.kind !== m_tuser[0] || want.data_byte !== m_tdata[7:0] ||
              want.msg_type !== m_tdata[23:8] || want.frame_len !== m_tdata[39:24] ||
              want.status !== m_tdata[41:40]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected kind %0d byte %h type %h len %h status %0d",
                       want.kind, want.data_byte, want.msg_type, want.frame_len,
                       want.status);
              $display("                 actual   kind %0d byte %h type %h len %h status %0d",
                       m_tuser[0], m_tdata[7:0], m_tdata[23:8], m_tdata[39:24],
                       m_tdata[41:40]);
            end
          end
        end
      end
      fail_count    <= mismatches;
      pending_count <= due_results.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver testbench
// Sends directed and random framed byte streams in both decoding modes, with
// random gaps and stalls on both sides, a long receiver hold-off and a full
// drain pause. A checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int          PHASE_BYTES     = 143;

  // Ways a generated frame can be damaged.
  typedef enum int {
    FAULT_NONE,
    FAULT_CHECK,
    FAULT_CUT,
    FAULT_EXTRA,
    FAULT_ESC_TAIL
  } fault_t;

  logic                        clk;
  logic                        rst         = 1'b1;
  logic                        cfg_wr_en   = 1'b0;
  logic                        cfg_wr_data = 1'b0;
  logic                        s_tvalid    = 1'b0;
  logic                        s_tready;
  logic [7:0]                  s_tdata     = 8'h00;
  logic                        m_tvalid;
  logic                        m_tready    = 1'b0;
  logic [efr_pkg::TDATA_W-1:0] m_tdata;
  logic [0:0]                  m_tuser;

  int                  fail_count;
  int                  pending_count;

  int                  sender_idle    = 0;
  int                  receiver_stall = 0;
  bit                  hold_req       = 1'b0;
  logic                mode_now       = 1'b0;
  int                  phase_bytes    = 0;
  int unsigned         cycles;

  escaped_frame_receiver_crc16 dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  efr_checker rx_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_stall);
      end
    end
  end

  // Offer one line byte, after an optional random gap, and wait for the request
  // to be taken. Valid stays high afterwards so back-to-back bytes never dip.
  task automatic send_byte(input logic [7:0] b);
    if (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    phase_bytes++;
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic drain;
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Change the decoding mode while the block is idle.
  task automatic write_mode(input logic v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_now = v;
  endtask

  // Build one frame with a random payload and a CRC or word-sum check, damage
  // it as asked, and put it on the line in the encoding of the current mode.
  task automatic send_frame(input logic [15:0] typ, input logic [15:0] plen,
                            input fault_t fault, input bit by_crc);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [15:0] chk;
    logic [31:0] sum;
    logic [16:0] fold;
    logic [7:0]  b;
    int unsigned keep;
    body = {typ[15:8], typ[7:0], plen[15:8], plen[7:0]};
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      // Flags in the payload break counted frames; keep most of them out.
      if (mode_now && b == efr_pkg::FLAG_BYTE && $urandom_range(7) != 0) begin
        b = 8'($urandom_range(8'h7D));
      end
      body.insert(body.size(), b);
    end
    crc = 16'h0000;
    sum = 32'd0;
    foreach (body[i]) begin
      for (int k = 7; k >= 0; k--) begin
        crc = {crc[14:0], 1'b0} ^ ((crc[15] ^ body[i][k]) ? efr_pkg::CRC_POLY : 16'h0000);
      end
      sum = sum + ((i % 2 == 0) ? {16'd0, body[i], 8'd0} : {24'd0, body[i]});
    end
    fold = {1'b0, sum[31:16]} + {1'b0, sum[15:0]};
    fold = fold + {16'd0, fold[16]};
    chk  = by_crc ? crc : ~fold[15:0];
    if (fault == FAULT_CHECK) chk = chk ^ (16'h0001 << $urandom_range(15));
    body.insert(body.size(), chk[15:8]);
    body.insert(body.size(), chk[7:0]);
    if (fault == FAULT_CUT) begin
      keep = $urandom_range(body.size() - 1);
      while (body.size() > keep) void'(body.pop_back());
    end
    if (fault == FAULT_EXTRA) begin
      repeat ($urandom_range(1, 3)) body.insert(body.size(), 8'($urandom));
    end
    send_byte(efr_pkg::FLAG_BYTE);
    foreach (body[i]) begin
      // Codes must be escaped; other bytes are escaped now and then, except
      // the one whose escaped form would be a flag.
      if (!mode_now && (body[i] == efr_pkg::FLAG_BYTE || body[i] == efr_pkg::ESC_BYTE ||
          (body[i] != (efr_pkg::FLAG_BYTE ^ efr_pkg::ESC_XOR) &&
           $urandom_range(15) == 0))) begin
        send_byte(efr_pkg::ESC_BYTE);
        send_byte(body[i] ^ efr_pkg::ESC_XOR);
      end else begin
        send_byte(body[i]);
      end
    end
    if (fault == FAULT_ESC_TAIL) send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::FLAG_BYTE);
  endtask

  // One random frame, sometimes preceded by line noise.
  task automatic random_frame;
    fault_t      fault;
    logic [15:0] plen;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) fault = FAULT_NONE;
    else if (pick < 77) fault = FAULT_CHECK;
    else if (pick < 89) fault = FAULT_CUT;
    else if (pick < 95) fault = FAULT_EXTRA;
    else fault = FAULT_ESC_TAIL;
    if ($urandom_range(15) == 0) plen = 16'($urandom_range(10, 60));
    else plen = 16'($urandom_range(9));
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
    send_frame(16'($urandom), plen, fault, bit'($urandom_range(1)));
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // Escape mode: noise while hunting, an empty frame, then a short frame
    // that ends in an escape kept as a literal byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(efr_pkg::FLAG_BYTE);
    send_byte(efr_pkg::FLAG_BYTE);
    send_byte(8'h12);
    send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::FLAG_BYTE);
    // Length field of all ones with escaped code bytes as payload.
    send_byte(efr_pkg::FLAG_BYTE);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::FLAG_BYTE ^ efr_pkg::ESC_XOR);
    send_byte(efr_pkg::ESC_BYTE);
    send_byte(efr_pkg::ESC_BYTE ^ efr_pkg::ESC_XOR);
    send_byte(efr_pkg::FLAG_BYTE);
    send_frame(16'hFFFF, 16'd1, FAULT_NONE, 1'b1);

    // Counting mode: a clean empty-payload frame, a dropped partial frame,
    // and an overlong frame.
    write_mode(1'b1);
    send_frame(16'h0000, 16'd0, FAULT_NONE, 1'b0);
    send_byte(efr_pkg::FLAG_BYTE);
    send_byte(8'h01);
    send_byte(efr_pkg::FLAG_BYTE);
    send_frame(16'h1234, 16'd2, FAULT_EXTRA, 1'b1);

    // Random phases over every idling pattern in both modes.
    for (int p = 0; p < 8; p++) begin
      write_mode(p[0] ^ p[2]);
      case (p % 4)
        0: begin
          sender_idle    = 0;
          receiver_stall = 0;
        end
        1: begin
          sender_idle    = 80;
          receiver_stall = 0;
        end
        2: begin
          sender_idle    = 0;
          receiver_stall = 80;
        end
        default: begin
          sender_idle    = 6;
          receiver_stall = 6;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        // Long receiver hold-off while bytes keep coming.
        if (p == 0 && !held && phase_bytes >= 40) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        // Sender pause until the block has emptied.
        if (p == 2 && !paused && phase_bytes >= 60) begin
          drain();
          paused = 1'b1;
        end
        random_frame();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
